FILE: hdl/wud_pkg.sv
// Package with the widths, transaction types and controller interface of the wide divider.
package wud_pkg;

	localparam int WORD_COUNT = 4;
	localparam int WORD_W = 32;
	localparam int OPER_W = WORD_COUNT * WORD_W;
	localparam int WCNT_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BCNT_W = $clog2(OPER_W);

	typedef struct packed {
		logic [WORD_W-1:0] dividend_word;
		logic [WORD_W-1:0] divisor_word;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] quotient_word;
		logic              divide_by_zero;
		logic              last_word;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
		logic shift_out;
	} dp_cmd_t;

	typedef struct packed {
		logic divisor_zero;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_LOAD   = 4'b0001,
		ST_SETUP  = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

endpackage

FILE: hdl/wide_unsigned_divider_top.sv
// Top level of the multiword unsigned integer divider.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data: dividend_word, divisor_word
// out       output     out_valid/out_stall  out_data: quotient_word, divide_by_zero, last_word
//
// An operand pair takes WORD_COUNT input transactions, a setup step, a divide of WORD_COUNT*32
// quotient bits and WORD_COUNT output transactions.
// The divide time is set by the restoring subtractor, which retires one quotient bit a cycle.
// A zero divisor skips the divide and gives a zero quotient with divide_by_zero set.
// Reset returns the block to loading the most significant word of a new operand pair.
// Stalls on the output hold the current quotient word; no input is taken until all are sent.
module wide_unsigned_divider_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wud_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output wud_pkg::out_item_t out_data
);
	import wud_pkg::*;

	dp_cmd_t           cmd;
	dp_status_t        status;
	logic [WORD_W-1:0] quotient_word;
	logic              divide_by_zero;
	logic              last_word;

	wud_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_word (last_word),
		.status    (status),
		.cmd       (cmd)
	);

	wud_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_item        (in_data),
		.status         (status),
		.quotient_word  (quotient_word),
		.divide_by_zero (divide_by_zero)
	);

	assign out_data.quotient_word = quotient_word;
	assign out_data.divide_by_zero = divide_by_zero;
	assign out_data.last_word = last_word;

endmodule

FILE: hdl/wud_datapath.sv
// Datapath of the wide divider: operand registers, remainder and shift-subtract step.
module wud_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wud_pkg::dp_cmd_t       cmd,
	input  wud_pkg::in_item_t      in_item,
	output wud_pkg::dp_status_t    status,
	output logic [wud_pkg::WORD_W-1:0] quotient_word,
	output logic                   divide_by_zero
);
	import wud_pkg::*;

	logic [OPER_W-1:0] dividend_q;
	logic [OPER_W-1:0] divisor_q;
	logic [OPER_W-1:0] rem_q;
	logic              dz_q;
	logic [OPER_W:0]   shifted;
	logic [OPER_W:0]   diff;

	assign shifted = {rem_q, dividend_q[OPER_W-1]};
	assign diff = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dividend_q <= (dividend_q << WORD_W) | OPER_W'(in_item.dividend_word);
			divisor_q  <= (divisor_q << WORD_W) | OPER_W'(in_item.divisor_word);
		end else if (cmd.setup) begin
			rem_q <= '0;
			if (status.divisor_zero) begin
				dividend_q <= '0;
			end
		end else if (cmd.step) begin
			if (!diff[OPER_W]) begin
				rem_q <= diff[OPER_W-1:0];
				dividend_q <= {dividend_q[OPER_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[OPER_W-1:0];
				dividend_q <= {dividend_q[OPER_W-2:0], 1'b0};
			end
		end else if (cmd.shift_out) begin
			dividend_q <= dividend_q << WORD_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= 1'b0;
		end else if (cmd.setup) begin
			dz_q <= status.divisor_zero;
		end
	end

	assign status.divisor_zero = (divisor_q == '0);
	assign quotient_word = dividend_q[OPER_W-1 -: WORD_W];
	assign divide_by_zero = dz_q;

endmodule

FILE: hdl/wud_controller.sv
// Controller state machine of the wide divider with its word and bit counters.
module wud_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                last_word,
	input  wud_pkg::dp_status_t status,
	output wud_pkg::dp_cmd_t    cmd
);
	import wud_pkg::*;

	state_t            state_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic              in_acc;
	logic              out_acc;
	logic              wcnt_last;

	assign in_stall = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign wcnt_last = (wcnt_q == WCNT_W'(WORD_COUNT - 1));
	assign last_word = wcnt_last;

	assign cmd.load = in_acc;
	assign cmd.setup = (state_q == ST_SETUP);
	assign cmd.step = (state_q == ST_DIVIDE);
	assign cmd.shift_out = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			wcnt_q <= '0;
			bcnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (wcnt_last) begin
							wcnt_q <= '0;
							state_q <= ST_SETUP;
						end else begin
							wcnt_q <= wcnt_q + 1'b1;
						end
					end
				end
				ST_SETUP: begin
					bcnt_q <= '0;
					state_q <= status.divisor_zero ? ST_EMIT : ST_DIVIDE;
				end
				ST_DIVIDE: begin
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == BCNT_W'(OPER_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (wcnt_last) begin
							wcnt_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							wcnt_q <= wcnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("input taken while a result is pending");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wcnt_last) |=> (state_q == ST_SETUP))
		else $error("last operand word did not start the divide");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP && !status.divisor_zero) |=>
		(state_q == ST_DIVIDE && bcnt_q == '0))
		else $error("divide did not start at bit zero");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && wcnt_last) |=> (state_q == ST_LOAD && wcnt_q == '0))
		else $error("controller did not return to loading after the last word");

endmodule
